### design/scp2d_pkg.sv
// ----------------------------------------------------------------------------
// scp2d_pkg
// Shared widths, constants and word types of the segment closest points block.
// ----------------------------------------------------------------------------
package scp2d_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int FIELD_BITS         = 16;
   localparam int PARAM_BITS         = 17;
   localparam int FRAC_BITS          = 16;
   localparam int POINT_FRAC         = 8;
   localparam int POINT_BITS         = 24;
   localparam int DIST_BITS          = 49;
   localparam int LIMIT_BITS         = 16;

   localparam logic [LIMIT_BITS-1:0] TOUCH_LIMIT_RESET = 16'd1;
   localparam logic [PARAM_BITS-1:0] PARAM_ONE         = 17'h10000;

   typedef struct packed {
      logic                         mode;
      logic signed [FIELD_BITS-1:0] seg_a_start_x;
      logic signed [FIELD_BITS-1:0] seg_a_start_y;
      logic signed [FIELD_BITS-1:0] seg_a_end_x;
      logic signed [FIELD_BITS-1:0] seg_a_end_y;
      logic signed [FIELD_BITS-1:0] seg_b_start_x;
      logic signed [FIELD_BITS-1:0] seg_b_start_y;
      logic signed [FIELD_BITS-1:0] seg_b_end_x;
      logic signed [FIELD_BITS-1:0] seg_b_end_y;
   } req_word_type;

   typedef struct packed {
      logic        [PARAM_BITS-1:0] param_on_a;
      logic        [PARAM_BITS-1:0] param_on_b;
      logic signed [POINT_BITS-1:0] closest_x;
      logic signed [POINT_BITS-1:0] closest_y;
      logic        [DIST_BITS-1:0]  dist_squared;
      logic                         touching;
   } rsp_word_type;

endpackage

### design/segment_closest_points_2d.sv
// ----------------------------------------------------------------------------
// segment_closest_points_2d
// Closest points between two 2D segments, or between a point and a segment.
//
// A request word carries the mode and both segments; one response word comes
// back per request, in order, with both segment parameters in Q1.16, the
// closest point on segment A in Q.8, the squared distance in Q.16 and a
// touching flag. The csr channel writes the touch limit; csr_ready is always
// high and the limit resets to 1.
// Throughput is one word per cycle while req_ready is high. A word passes
// through the setup stages, the two 16-step restoring dividers that run one
// quotient bit per stage, and the distance stages on its way to rsp_valid.
// Reset clears every valid bit, but not the response data; data in flight is
// dropped. When the receiver stalls, the response register holds its word and
// a skid register takes the next one, then the whole pipeline holds and
// req_ready drops until the skid register drains; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module segment_closest_points_2d #(
   parameter int COORD_BITS = scp2d_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  scp2d_pkg::req_word_type             req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output scp2d_pkg::rsp_word_type             rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [scp2d_pkg::LIMIT_BITS-1:0]    csr_data
);
   import scp2d_pkg::*;

   localparam int CB    = COORD_BITS;
   localparam int CW    = CB + 1;
   localparam int PW    = 2 * CB + 4;
   localparam int MW    = CW + PARAM_BITS + 1;
   localparam int QW    = CB + 10;
   localparam int EW    = QW + 1;
   localparam int DW    = 2 * EW + 1;
   localparam int DCW   = (DW > 64) ? 64 : DW;
   localparam int STEPS = FRAC_BITS;
   localparam int RND_SHIFT  = FRAC_BITS - POINT_FRAC;
   localparam int ROUND_HALF = 1 << (RND_SHIFT - 1);

   localparam logic [1:0] SRC_DIV  = 2'd0;
   localparam logic [1:0] SRC_ZERO = 2'd1;
   localparam logic [1:0] SRC_ONE  = 2'd2;

   typedef struct packed {
      logic          mode;
      logic [CB-1:0] ax, ay, bx, by;
      logic [CW-1:0] adx, ady, bdx, bdy;
   } geo_type;

   typedef struct packed {
      logic [1:0] src_a;
      logic [1:0] src_b;
      logic       neither;
      logic       cross_hit;
      logic       n1_neg;
      logic       n2_neg;
   } sel_type;

   typedef struct packed {
      logic [2*CW-1:0] cra, crb, n1a, n1b, n2a, n2b, laa, lab, lba, lbb;
      logic [2*CW-1:0] dpa, dpb, wa1, wa2, wb1, wb2;
   } prod_type;

   logic en;
   logic [LIMIT_BITS-1:0] limit_ff;

   // stage valids
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, vf_ff, vp1_ff, vp2_ff, vp3_ff, vp4_ff;
   logic [STEPS:0] vd_ff;

   // stage 0: request register
   req_word_type w0_ff;

   // stage 1: coordinates and differences
   logic signed [CB-1:0] ax0, ay0, aex0, aey0, bx0, by0, bex0, bey0;
   geo_type g1_in, g1_ff;
   logic [CW-1:0] wx1_in, wy1_in, wx1_ff, wy1_ff;

   // stage 2: products
   logic signed [CW-1:0] adx1, ady1, bdx1, bdy1, wx1, wy1;
   prod_type pr2_in, pr2_ff;
   geo_type  g2_ff;
   logic     az2_ff, bz2_ff;

   // stage 3: sums
   logic signed [PW-1:0] cr3_in, n1c3_in, n2c3_in, wda3_in, wdb3_in, lena3_in, lenb3_in,
                         dot3_in;
   logic signed [PW-1:0] cr3_ff, n1c3_ff, n2c3_ff, wda3_ff, wdb3_ff, lena3_ff, lenb3_ff,
                         dot3_ff;
   geo_type g3_ff;
   logic    az3_ff, bz3_ff;

   // stage 4: normalized line parameters
   logic signed [PW-1:0] n1_4_in, d1_4_in, n2_4_in, d2_4_in, naalt4_in, nbalt4_in, nwdb4_in;
   logic signed [PW-1:0] n1_4_ff, d1_4_ff, n2_4_ff, d2_4_ff, naalt4_ff, nbalt4_ff, nwdb4_ff;
   logic signed [PW-1:0] wda4_ff, lena4_ff, lenb4_ff;
   logic    crnz4_ff, az4_ff, bz4_ff;
   geo_type g4_ff;

   // stage 5: case decode and divider operands
   logic signed [PW-1:0] na5_in, da5_in, nb5_in, db5_in;
   logic signed [PW-1:0] na5_ff, da5_ff, nb5_ff, db5_ff;
   sel_type s5_in, s5_ff;
   geo_type g5_ff;
   logic    in1_5, in2_5;

   // divider stages
   logic [PW-1:0]        dra_ff [0:STEPS];
   logic [PW-1:0]        dda_ff [0:STEPS];
   logic [PW-1:0]        drb_ff [0:STEPS];
   logic [PW-1:0]        ddb_ff [0:STEPS];
   logic [FRAC_BITS-1:0] dqa_ff [0:STEPS];
   logic [FRAC_BITS-1:0] dqb_ff [0:STEPS];
   logic [STEPS:0]       dza_ff, doa_ff, dzb_ff, dob_ff;
   geo_type              dg_ff [0:STEPS];
   sel_type              ds_ff [0:STEPS];
   logic [PW-1:0]        dra_in [1:STEPS];
   logic [PW-1:0]        drb_in [1:STEPS];
   logic [FRAC_BITS-1:0] dqa_in [1:STEPS];
   logic [FRAC_BITS-1:0] dqb_in [1:STEPS];

   // stage F: parameters resolved
   logic [PARAM_BITS-1:0] ta_div, tb_div, taf_in, tbf_in, taf_ff, tbf_ff;
   geo_type gf_ff;
   sel_type sf_ff;

   // stage P1: direction times parameter
   logic signed [MW-1:0] mxa1_in, mya1_in, mxb1_in, myb1_in;
   logic signed [MW-1:0] mxa1_ff, mya1_ff, mxb1_ff, myb1_ff;
   logic [PARAM_BITS-1:0] ta1_ff, tb1_ff;
   geo_type g1p_ff;
   sel_type s1p_ff;

   // stage P2: rounded points and differences
   logic signed [MW-1:0] vax, vay, vbx, vby;
   logic signed [QW-1:0] pax2, pay2, pbx2, pby2, qax2, qay2, qbx2, qby2;
   logic signed [EW-1:0] dmx2_in, dmy2_in, dax2_in, day2_in, dbx2_in, dby2_in;
   logic signed [EW-1:0] dmx2_ff, dmy2_ff, dax2_ff, day2_ff, dbx2_ff, dby2_ff;
   logic signed [QW-1:0] pax2_ff, pay2_ff, qax2_ff, qay2_ff;
   logic [PARAM_BITS-1:0] ta2_ff, tb2_ff;
   sel_type s2p_ff;

   // stage P3: squares
   logic [2*EW-1:0] smx3_ff, smy3_ff, sax3_ff, say3_ff, sbx3_ff, sby3_ff;
   logic signed [QW-1:0] pax3_ff, pay3_ff, qax3_ff, qay3_ff;
   logic [PARAM_BITS-1:0] ta3_ff, tb3_ff;
   sel_type s3p_ff;

   // stage P4: distance sums
   logic [DW-1:0] dm4_ff, da4_ff, db4_ff;
   logic signed [QW-1:0] pax4_ff, pay4_ff, qax4_ff, qay4_ff;
   logic [PARAM_BITS-1:0] ta4_ff, tb4_ff;
   sel_type s4p_ff;

   // response
   rsp_word_type res_in, rsp_word_ff, skid_ff;
   logic         rsp_valid_ff, skid_valid_ff;
   logic [DW-1:0] dist_sel;

   assign en        = !skid_valid_ff;
   assign req_ready = en;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= TOUCH_LIMIT_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

   // stage 1
   assign ax0  = CB'($unsigned(w0_ff.seg_a_start_x));
   assign ay0  = CB'($unsigned(w0_ff.seg_a_start_y));
   assign aex0 = CB'($unsigned(w0_ff.seg_a_end_x));
   assign aey0 = CB'($unsigned(w0_ff.seg_a_end_y));
   assign bx0  = CB'($unsigned(w0_ff.seg_b_start_x));
   assign by0  = CB'($unsigned(w0_ff.seg_b_start_y));
   assign bex0 = CB'($unsigned(w0_ff.seg_b_end_x));
   assign bey0 = CB'($unsigned(w0_ff.seg_b_end_y));

   always_comb begin
      g1_in.mode = w0_ff.mode;
      g1_in.ax   = ax0;
      g1_in.ay   = ay0;
      g1_in.bx   = bx0;
      g1_in.by   = by0;
      g1_in.adx  = CW'(aex0) - CW'(ax0);
      g1_in.ady  = CW'(aey0) - CW'(ay0);
      g1_in.bdx  = CW'(bex0) - CW'(bx0);
      g1_in.bdy  = CW'(bey0) - CW'(by0);
      wx1_in     = CW'(bx0) - CW'(ax0);
      wy1_in     = CW'(by0) - CW'(ay0);
   end

   // stage 2
   assign adx1 = g1_ff.adx;
   assign ady1 = g1_ff.ady;
   assign bdx1 = g1_ff.bdx;
   assign bdy1 = g1_ff.bdy;
   assign wx1  = wx1_ff;
   assign wy1  = wy1_ff;

   always_comb begin
      pr2_in.cra = adx1 * bdy1;
      pr2_in.crb = ady1 * bdx1;
      pr2_in.n1a = wx1 * bdy1;
      pr2_in.n1b = wy1 * bdx1;
      pr2_in.n2a = wx1 * ady1;
      pr2_in.n2b = wy1 * adx1;
      pr2_in.laa = adx1 * adx1;
      pr2_in.lab = ady1 * ady1;
      pr2_in.lba = bdx1 * bdx1;
      pr2_in.lbb = bdy1 * bdy1;
      pr2_in.dpa = adx1 * bdx1;
      pr2_in.dpb = ady1 * bdy1;
      pr2_in.wa1 = wx1 * adx1;
      pr2_in.wa2 = wy1 * ady1;
      pr2_in.wb1 = wx1 * bdx1;
      pr2_in.wb2 = wy1 * bdy1;
   end

   // stage 3
   assign cr3_in   = PW'($signed(pr2_ff.cra)) - PW'($signed(pr2_ff.crb));
   assign n1c3_in  = PW'($signed(pr2_ff.n1a)) - PW'($signed(pr2_ff.n1b));
   assign n2c3_in  = PW'($signed(pr2_ff.n2a)) - PW'($signed(pr2_ff.n2b));
   assign lena3_in = PW'($signed(pr2_ff.laa)) + PW'($signed(pr2_ff.lab));
   assign lenb3_in = PW'($signed(pr2_ff.lba)) + PW'($signed(pr2_ff.lbb));
   assign dot3_in  = PW'($signed(pr2_ff.dpa)) + PW'($signed(pr2_ff.dpb));
   assign wda3_in  = PW'($signed(pr2_ff.wa1)) + PW'($signed(pr2_ff.wa2));
   assign wdb3_in  = PW'($signed(pr2_ff.wb1)) + PW'($signed(pr2_ff.wb2));

   // stage 4
   always_comb begin
      if (cr3_ff != 0) begin
         n1_4_in = cr3_ff[PW-1] ? -n1c3_ff : n1c3_ff;
         n2_4_in = cr3_ff[PW-1] ? -n2c3_ff : n2c3_ff;
         d1_4_in = cr3_ff[PW-1] ? -cr3_ff : cr3_ff;
         d2_4_in = d1_4_in;
      end else begin
         n1_4_in = '0;
         d1_4_in = PW'(1);
         n2_4_in = -wdb3_ff;
         d2_4_in = lenb3_ff;
      end
      naalt4_in = wda3_ff + dot3_ff;
      nbalt4_in = dot3_ff - wdb3_ff;
      nwdb4_in  = -wdb3_ff;
   end

   // stage 5
   assign in1_5 = (n1_4_ff >= 0) && (n1_4_ff <= d1_4_ff);
   assign in2_5 = (n2_4_ff >= 0) && (n2_4_ff <= d2_4_ff);

   always_comb begin
      na5_in          = wda4_ff;
      da5_in          = lena4_ff;
      nb5_in          = nwdb4_ff;
      db5_in          = lenb4_ff;
      s5_in.src_a     = SRC_DIV;
      s5_in.src_b     = SRC_ZERO;
      s5_in.neither   = 1'b0;
      s5_in.cross_hit = 1'b0;
      s5_in.n1_neg    = n1_4_ff[PW-1];
      s5_in.n2_neg    = n2_4_ff[PW-1];
      if (!g4_ff.mode || (bz4_ff && !az4_ff)) begin
         s5_in.src_a = SRC_DIV;
         s5_in.src_b = SRC_ZERO;
      end else if (az4_ff && bz4_ff) begin
         s5_in.src_a = SRC_ZERO;
         s5_in.src_b = SRC_ZERO;
      end else if (az4_ff) begin
         s5_in.src_a = SRC_ZERO;
         s5_in.src_b = SRC_DIV;
      end else if (in1_5 && in2_5) begin
         na5_in          = n1_4_ff;
         da5_in          = d1_4_ff;
         nb5_in          = n2_4_ff;
         db5_in          = d2_4_ff;
         s5_in.src_a     = SRC_DIV;
         s5_in.src_b     = SRC_DIV;
         s5_in.cross_hit = crnz4_ff;
      end else begin
         na5_in = n2_4_ff[PW-1] ? wda4_ff : naalt4_ff;
         nb5_in = n1_4_ff[PW-1] ? nwdb4_ff : nbalt4_ff;
         if (in1_5) begin
            s5_in.src_a = SRC_DIV;
            s5_in.src_b = n2_4_ff[PW-1] ? SRC_ZERO : SRC_ONE;
         end else if (in2_5) begin
            s5_in.src_a = n1_4_ff[PW-1] ? SRC_ZERO : SRC_ONE;
            s5_in.src_b = SRC_DIV;
         end else begin
            s5_in.src_a   = SRC_DIV;
            s5_in.src_b   = SRC_DIV;
            s5_in.neither = 1'b1;
         end
      end
   end

   // restoring division, one quotient bit per stage
   always_comb begin
      logic [PW-1:0] sha, shb;
      for (int k = 1; k <= STEPS; k++) begin
         sha = {dra_ff[k-1][PW-2:0], 1'b0};
         shb = {drb_ff[k-1][PW-2:0], 1'b0};
         if (sha >= dda_ff[k-1]) begin
            dra_in[k] = sha - dda_ff[k-1];
            dqa_in[k] = {dqa_ff[k-1][FRAC_BITS-2:0], 1'b1};
         end else begin
            dra_in[k] = sha;
            dqa_in[k] = {dqa_ff[k-1][FRAC_BITS-2:0], 1'b0};
         end
         if (shb >= ddb_ff[k-1]) begin
            drb_in[k] = shb - ddb_ff[k-1];
            dqb_in[k] = {dqb_ff[k-1][FRAC_BITS-2:0], 1'b1};
         end else begin
            drb_in[k] = shb;
            dqb_in[k] = {dqb_ff[k-1][FRAC_BITS-2:0], 1'b0};
         end
      end
   end

   // stage F
   always_comb begin
      if (dza_ff[STEPS]) begin
         ta_div = '0;
      end else if (doa_ff[STEPS]) begin
         ta_div = PARAM_ONE;
      end else begin
         ta_div = {1'b0, dqa_ff[STEPS]};
      end
      if (dzb_ff[STEPS]) begin
         tb_div = '0;
      end else if (dob_ff[STEPS]) begin
         tb_div = PARAM_ONE;
      end else begin
         tb_div = {1'b0, dqb_ff[STEPS]};
      end
      case (ds_ff[STEPS].src_a)
         SRC_DIV:  taf_in = ta_div;
         SRC_ONE:  taf_in = PARAM_ONE;
         default:  taf_in = '0;
      endcase
      case (ds_ff[STEPS].src_b)
         SRC_DIV:  tbf_in = tb_div;
         SRC_ONE:  tbf_in = PARAM_ONE;
         default:  tbf_in = '0;
      endcase
   end

   // stage P1
   assign mxa1_in = $signed(gf_ff.adx) * $signed({1'b0, taf_ff});
   assign mya1_in = $signed(gf_ff.ady) * $signed({1'b0, taf_ff});
   assign mxb1_in = $signed(gf_ff.bdx) * $signed({1'b0, tbf_ff});
   assign myb1_in = $signed(gf_ff.bdy) * $signed({1'b0, tbf_ff});

   // stage P2
   always_comb begin
      vax  = (MW'($signed(g1p_ff.ax)) <<< FRAC_BITS) + mxa1_ff + MW'(ROUND_HALF);
      vay  = (MW'($signed(g1p_ff.ay)) <<< FRAC_BITS) + mya1_ff + MW'(ROUND_HALF);
      vbx  = (MW'($signed(g1p_ff.bx)) <<< FRAC_BITS) + mxb1_ff + MW'(ROUND_HALF);
      vby  = (MW'($signed(g1p_ff.by)) <<< FRAC_BITS) + myb1_ff + MW'(ROUND_HALF);
      pax2 = QW'(vax >>> RND_SHIFT);
      pay2 = QW'(vay >>> RND_SHIFT);
      pbx2 = QW'(vbx >>> RND_SHIFT);
      pby2 = QW'(vby >>> RND_SHIFT);
      if (s1p_ff.n1_neg) begin
         qax2 = QW'($signed(g1p_ff.ax)) <<< POINT_FRAC;
         qay2 = QW'($signed(g1p_ff.ay)) <<< POINT_FRAC;
      end else begin
         qax2 = (QW'($signed(g1p_ff.ax)) + QW'($signed(g1p_ff.adx))) <<< POINT_FRAC;
         qay2 = (QW'($signed(g1p_ff.ay)) + QW'($signed(g1p_ff.ady))) <<< POINT_FRAC;
      end
      if (s1p_ff.n2_neg) begin
         qbx2 = QW'($signed(g1p_ff.bx)) <<< POINT_FRAC;
         qby2 = QW'($signed(g1p_ff.by)) <<< POINT_FRAC;
      end else begin
         qbx2 = (QW'($signed(g1p_ff.bx)) + QW'($signed(g1p_ff.bdx))) <<< POINT_FRAC;
         qby2 = (QW'($signed(g1p_ff.by)) + QW'($signed(g1p_ff.bdy))) <<< POINT_FRAC;
      end
      dmx2_in = EW'(pax2) - EW'(pbx2);
      dmy2_in = EW'(pay2) - EW'(pby2);
      dax2_in = EW'(pax2) - EW'(qbx2);
      day2_in = EW'(pay2) - EW'(qby2);
      dbx2_in = EW'(qax2) - EW'(pbx2);
      dby2_in = EW'(qay2) - EW'(pby2);
   end

   // response select
   always_comb begin
      res_in.param_on_a = ta4_ff;
      res_in.param_on_b = tb4_ff;
      res_in.closest_x  = POINT_BITS'(pax4_ff);
      res_in.closest_y  = POINT_BITS'(pay4_ff);
      dist_sel          = s4p_ff.cross_hit ? '0 : dm4_ff;
      if (s4p_ff.neither) begin
         if (DCW'(da4_ff) <= DCW'(db4_ff)) begin
            res_in.param_on_b = s4p_ff.n2_neg ? '0 : PARAM_ONE;
            dist_sel          = da4_ff;
         end else begin
            res_in.param_on_a = s4p_ff.n1_neg ? '0 : PARAM_ONE;
            res_in.closest_x  = POINT_BITS'(qax4_ff);
            res_in.closest_y  = POINT_BITS'(qay4_ff);
            dist_sel          = db4_ff;
         end
      end
      res_in.dist_squared = DIST_BITS'(dist_sel);
      res_in.touching     = (res_in.dist_squared <= DIST_BITS'(limit_ff));
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff  <= 1'b0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         vd_ff  <= '0;
         vf_ff  <= 1'b0;
         vp1_ff <= 1'b0;
         vp2_ff <= 1'b0;
         vp3_ff <= 1'b0;
         vp4_ff <= 1'b0;
      end else if (en) begin
         v0_ff  <= req_valid;
         v1_ff  <= v0_ff;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         v5_ff  <= v4_ff;
         vd_ff  <= {vd_ff[STEPS-1:0], v5_ff};
         vf_ff  <= vd_ff[STEPS];
         vp1_ff <= vf_ff;
         vp2_ff <= vp1_ff;
         vp3_ff <= vp2_ff;
         vp4_ff <= vp3_ff;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         w0_ff  <= req_data;

         g1_ff  <= g1_in;
         wx1_ff <= wx1_in;
         wy1_ff <= wy1_in;

         pr2_ff <= pr2_in;
         g2_ff  <= g1_ff;
         az2_ff <= (g1_ff.adx == '0) && (g1_ff.ady == '0);
         bz2_ff <= (g1_ff.bdx == '0) && (g1_ff.bdy == '0);

         cr3_ff   <= cr3_in;
         n1c3_ff  <= n1c3_in;
         n2c3_ff  <= n2c3_in;
         wda3_ff  <= wda3_in;
         wdb3_ff  <= wdb3_in;
         lena3_ff <= lena3_in;
         lenb3_ff <= lenb3_in;
         dot3_ff  <= dot3_in;
         g3_ff    <= g2_ff;
         az3_ff   <= az2_ff;
         bz3_ff   <= bz2_ff;

         n1_4_ff   <= n1_4_in;
         d1_4_ff   <= d1_4_in;
         n2_4_ff   <= n2_4_in;
         d2_4_ff   <= d2_4_in;
         naalt4_ff <= naalt4_in;
         nbalt4_ff <= nbalt4_in;
         nwdb4_ff  <= nwdb4_in;
         wda4_ff   <= wda3_ff;
         lena4_ff  <= lena3_ff;
         lenb4_ff  <= lenb3_ff;
         crnz4_ff  <= (cr3_ff != 0);
         az4_ff    <= az3_ff;
         bz4_ff    <= bz3_ff;
         g4_ff     <= g3_ff;

         na5_ff <= na5_in;
         da5_ff <= da5_in;
         nb5_ff <= nb5_in;
         db5_ff <= db5_in;
         s5_ff  <= s5_in;
         g5_ff  <= g4_ff;

         dra_ff[0] <= na5_ff;
         dda_ff[0] <= da5_ff;
         drb_ff[0] <= nb5_ff;
         ddb_ff[0] <= db5_ff;
         dqa_ff[0] <= '0;
         dqb_ff[0] <= '0;
         dza_ff[0] <= (na5_ff <= 0);
         doa_ff[0] <= (na5_ff >= da5_ff);
         dzb_ff[0] <= (nb5_ff <= 0);
         dob_ff[0] <= (nb5_ff >= db5_ff);
         dg_ff[0]  <= g5_ff;
         ds_ff[0]  <= s5_ff;
         for (int k = 1; k <= STEPS; k++) begin
            dra_ff[k] <= dra_in[k];
            drb_ff[k] <= drb_in[k];
            dqa_ff[k] <= dqa_in[k];
            dqb_ff[k] <= dqb_in[k];
            dda_ff[k] <= dda_ff[k-1];
            ddb_ff[k] <= ddb_ff[k-1];
            dza_ff[k] <= dza_ff[k-1];
            doa_ff[k] <= doa_ff[k-1];
            dzb_ff[k] <= dzb_ff[k-1];
            dob_ff[k] <= dob_ff[k-1];
            dg_ff[k]  <= dg_ff[k-1];
            ds_ff[k]  <= ds_ff[k-1];
         end

         taf_ff <= taf_in;
         tbf_ff <= tbf_in;
         gf_ff  <= dg_ff[STEPS];
         sf_ff  <= ds_ff[STEPS];

         mxa1_ff <= mxa1_in;
         mya1_ff <= mya1_in;
         mxb1_ff <= mxb1_in;
         myb1_ff <= myb1_in;
         ta1_ff  <= taf_ff;
         tb1_ff  <= tbf_ff;
         g1p_ff  <= gf_ff;
         s1p_ff  <= sf_ff;

         dmx2_ff <= dmx2_in;
         dmy2_ff <= dmy2_in;
         dax2_ff <= dax2_in;
         day2_ff <= day2_in;
         dbx2_ff <= dbx2_in;
         dby2_ff <= dby2_in;
         pax2_ff <= pax2;
         pay2_ff <= pay2;
         qax2_ff <= qax2;
         qay2_ff <= qay2;
         ta2_ff  <= ta1_ff;
         tb2_ff  <= tb1_ff;
         s2p_ff  <= s1p_ff;

         smx3_ff <= dmx2_ff * dmx2_ff;
         smy3_ff <= dmy2_ff * dmy2_ff;
         sax3_ff <= dax2_ff * dax2_ff;
         say3_ff <= day2_ff * day2_ff;
         sbx3_ff <= dbx2_ff * dbx2_ff;
         sby3_ff <= dby2_ff * dby2_ff;
         pax3_ff <= pax2_ff;
         pay3_ff <= pay2_ff;
         qax3_ff <= qax2_ff;
         qay3_ff <= qay2_ff;
         ta3_ff  <= ta2_ff;
         tb3_ff  <= tb2_ff;
         s3p_ff  <= s2p_ff;

         dm4_ff  <= DW'(smx3_ff) + DW'(smy3_ff);
         da4_ff  <= DW'(sax3_ff) + DW'(say3_ff);
         db4_ff  <= DW'(sbx3_ff) + DW'(sby3_ff);
         pax4_ff <= pax3_ff;
         pay4_ff <= pay3_ff;
         qax4_ff <= qax3_ff;
         qay4_ff <= qay3_ff;
         ta4_ff  <= ta3_ff;
         tb4_ff  <= tb3_ff;
         s4p_ff  <= s3p_ff;
      end
   end

   // response register and skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_ff <= vp4_ff;
      end else if (vp4_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            rsp_word_ff <= skid_ff;
         end
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_word_ff <= res_in;
      end else begin
         skid_ff <= res_in;
      end
   end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks segment_closest_points_2d against a built-in predictor of the
// clamped closest-point math, over a directed table and random words, with
// random gaps on both channels, a long receiver stall and touch limit changes.
// ----------------------------------------------------------------------------
module testbench;
   import scp2d_pkg::*;

   localparam int LATENCY = 28;
   localparam int NUM_RANDOM = 1530;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_word_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_word_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [LIMIT_BITS-1:0] csr_data;

   logic [LIMIT_BITS-1:0] touch_limit;
   rsp_word_type expected_words[$];
   int error_count;
   bit hold_off;

   typedef struct {
      req_word_type word;
      bit has_answer;
      rsp_word_type answer;
   } row_type;
   row_type rows[$];

   segment_closest_points_2d DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50000000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic longint clamp_param(longint num, longint den);
      longint r;
      longint q;
      q = 0;
      if (num <= 0) return 0;
      if (num >= den) return 65536;
      r = num;
      for (int i = 0; i < 16; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 1;
         end
      end
      return q;
   endfunction

   function automatic longint project_onto(longint px, longint py, longint ax, longint ay,
                                           longint dx, longint dy);
      longint den;
      den = dx * dx + dy * dy;
      if (den == 0) return 0;
      return clamp_param((px - ax) * dx + (py - ay) * dy, den);
   endfunction

   function automatic longint point_q8(longint s, longint d, longint t);
      longint v;
      longint q;
      v = s * 65536 + d * t + 128;
      q = v / 256;
      if (v % 256 != 0 && v < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint squared_gap(longint x0, longint y0, longint x1, longint y1);
      return (x0 - x1) * (x0 - x1) + (y0 - y1) * (y0 - y1);
   endfunction

   function automatic rsp_word_type closest_points(req_word_type w);
      rsp_word_type r;
      longint ax, ay, adx, ady, bx, by, bdx, bdy;
      longint ta, tb, cr, wx, wy, n1, n2, d1, d2;
      longint pax, pay, pbx, pby, gap2;
      longint qax, qay, qbx, qby, t1, t2, da, db, ea, eb;
      bit hit, in1, in2, az, bz;
      ax = w.seg_a_start_x;
      ay = w.seg_a_start_y;
      adx = longint'(w.seg_a_end_x) - ax;
      ady = longint'(w.seg_a_end_y) - ay;
      bx = w.seg_b_start_x;
      by = w.seg_b_start_y;
      bdx = longint'(w.seg_b_end_x) - bx;
      bdy = longint'(w.seg_b_end_y) - by;
      ta = 0;
      tb = 0;
      hit = 0;
      az = (adx == 0 && ady == 0);
      bz = (bdx == 0 && bdy == 0);
      if (!w.mode || bz) begin
         ta = project_onto(bx, by, ax, ay, adx, ady);
      end else if (az) begin
         tb = project_onto(ax, ay, bx, by, bdx, bdy);
      end else begin
         cr = adx * bdy - ady * bdx;
         wx = bx - ax;
         wy = by - ay;
         if (cr != 0) begin
            n1 = wx * bdy - wy * bdx;
            n2 = wx * ady - wy * adx;
            d1 = cr;
            if (cr < 0) begin
               n1 = -n1;
               n2 = -n2;
               d1 = -cr;
            end
            d2 = d1;
         end else begin
            n1 = 0;
            d1 = 1;
            n2 = -wx * bdx - wy * bdy;
            d2 = bdx * bdx + bdy * bdy;
         end
         in1 = (n1 >= 0 && n1 <= d1);
         in2 = (n2 >= 0 && n2 <= d2);
         qax = n1 < 0 ? ax : ax + adx;
         qay = n1 < 0 ? ay : ay + ady;
         qbx = n2 < 0 ? bx : bx + bdx;
         qby = n2 < 0 ? by : by + bdy;
         ea = n1 < 0 ? 0 : 65536;
         eb = n2 < 0 ? 0 : 65536;
         if (in1 && in2) begin
            ta = clamp_param(n1, d1);
            tb = clamp_param(n2, d2);
            hit = (cr != 0);
         end else if (in1) begin
            tb = eb;
            ta = project_onto(qbx, qby, ax, ay, adx, ady);
         end else if (in2) begin
            ta = ea;
            tb = project_onto(qax, qay, bx, by, bdx, bdy);
         end else begin
            t1 = project_onto(qbx, qby, ax, ay, adx, ady);
            t2 = project_onto(qax, qay, bx, by, bdx, bdy);
            da = squared_gap(point_q8(ax, adx, t1), point_q8(ay, ady, t1),
                             qbx * 256, qby * 256);
            db = squared_gap(qax * 256, qay * 256,
                             point_q8(bx, bdx, t2), point_q8(by, bdy, t2));
            if (da <= db) begin
               ta = t1;
               tb = eb;
            end else begin
               ta = ea;
               tb = t2;
            end
         end
      end
      pax = point_q8(ax, adx, ta);
      pay = point_q8(ay, ady, ta);
      if (!w.mode) begin
         pbx = bx * 256;
         pby = by * 256;
      end else begin
         pbx = point_q8(bx, bdx, tb);
         pby = point_q8(by, bdy, tb);
      end
      gap2 = hit ? 0 : squared_gap(pax, pay, pbx, pby);
      r.param_on_a = ta[PARAM_BITS-1:0];
      r.param_on_b = tb[PARAM_BITS-1:0];
      r.closest_x = pax[POINT_BITS-1:0];
      r.closest_y = pay[POINT_BITS-1:0];
      r.dist_squared = gap2[DIST_BITS-1:0];
      r.touching = (gap2 <= longint'(touch_limit));
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
      error_count++;
   endtask

   function automatic int gap_length();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
   endfunction

   function automatic logic signed [FIELD_BITS-1:0] pick_coord(int span);
      case ($urandom_range(0, 9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2, 3: return 16'($urandom);
         default: return $signed(16'($urandom_range(0, 2 * span))) - 16'(span);
      endcase
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      int span;
      span = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(1, 60);
      w.mode = 1'($urandom);
      w.seg_a_start_x = pick_coord(span);
      w.seg_a_start_y = pick_coord(span);
      w.seg_a_end_x = pick_coord(span);
      w.seg_a_end_y = pick_coord(span);
      w.seg_b_start_x = pick_coord(span);
      w.seg_b_start_y = pick_coord(span);
      w.seg_b_end_x = pick_coord(span);
      w.seg_b_end_y = pick_coord(span);
      case ($urandom_range(0, 11))
         0: begin
            w.seg_a_end_x = w.seg_a_start_x;
            w.seg_a_end_y = w.seg_a_start_y;
         end
         1: begin
            w.seg_b_end_x = w.seg_b_start_x;
            w.seg_b_end_y = w.seg_b_start_y;
         end
         2: begin
            w.seg_b_end_x = w.seg_b_start_x + (w.seg_a_end_x - w.seg_a_start_x);
            w.seg_b_end_y = w.seg_b_start_y + (w.seg_a_end_y - w.seg_a_start_y);
         end
         default: ;
      endcase
      return w;
   endfunction

   function automatic req_word_type make_word(bit m, int a0, int a1, int a2, int a3,
                                              int b0, int b1, int b2, int b3);
      req_word_type w;
      w.mode = m;
      w.seg_a_start_x = 16'(a0);
      w.seg_a_start_y = 16'(a1);
      w.seg_a_end_x = 16'(a2);
      w.seg_a_end_y = 16'(a3);
      w.seg_b_start_x = 16'(b0);
      w.seg_b_start_y = 16'(b1);
      w.seg_b_end_x = 16'(b2);
      w.seg_b_end_y = 16'(b3);
      return w;
   endfunction

   task automatic add_row(req_word_type w, bit known, rsp_word_type a);
      row_type r;
      r.word = w;
      r.has_answer = known;
      r.answer = a;
      rows.push_back(r);
   endtask

   task automatic send_word(req_word_type w, bit known, rsp_word_type answer);
      rsp_word_type predicted;
      predicted = closest_points(w);
      if (known && predicted != answer) begin
         $display("table row disagrees with prediction at %0t", $time);
         error_count++;
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      expected_words.push_back(predicted);
   endtask

   task automatic idle_for(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      touch_limit = value;
      csr_valid <= 1'b0;
   endtask

   initial begin
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_off = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (gap_length() + 1) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $display("unexpected response word at %0t", $time);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_data.param_on_a != want.param_on_a)
               report_mismatch("param_on_a", rsp_data.param_on_a, want.param_on_a);
            if (rsp_data.param_on_b != want.param_on_b)
               report_mismatch("param_on_b", rsp_data.param_on_b, want.param_on_b);
            if (rsp_data.closest_x != want.closest_x)
               report_mismatch("closest_x", rsp_data.closest_x, want.closest_x);
            if (rsp_data.closest_y != want.closest_y)
               report_mismatch("closest_y", rsp_data.closest_y, want.closest_y);
            if (rsp_data.dist_squared != want.dist_squared)
               report_mismatch("dist_squared", rsp_data.dist_squared, want.dist_squared);
            if (rsp_data.touching != want.touching)
               report_mismatch("touching", rsp_data.touching, want.touching);
         end
      end
   end

   initial begin
      rsp_word_type a;
      logic [LIMIT_BITS-1:0] limits[4];
      error_count = 0;
      hold_off = 0;
      touch_limit = TOUCH_LIMIT_RESET;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      limits[0] = 16'd0;
      limits[1] = 16'hffff;
      limits[2] = 16'd300;
      limits[3] = 16'd1;

      // point on A start: all zero, touching under reset limit
      a = '{param_on_a: 0, param_on_b: 0, closest_x: 0, closest_y: 0,
            dist_squared: 0, touching: 1};
      add_row(make_word(0, 0, 0, 10, 0, 0, 0, 0, 0), 1, a);
      // point past A end clamps to the end
      a = '{param_on_a: PARAM_ONE, param_on_b: 0, closest_x: 2560, closest_y: 0,
            dist_squared: 65536 * 25, touching: 0};
      add_row(make_word(0, 0, 0, 10, 0, 15, 0, 0, 0), 1, a);
      // crossing segments: distance forced to zero
      a = '{param_on_a: 32768, param_on_b: 32768, closest_x: 0, closest_y: 0,
            dist_squared: 0, touching: 1};
      add_row(make_word(1, -4, 0, 4, 0, 0, -4, 0, 4), 1, a);
      add_row(make_word(1, 3, 3, 3, 3, 7, 7, 7, 7), 0, a);
      add_row(make_word(1, 3, 3, 3, 3, 0, 0, 10, 1), 0, a);
      add_row(make_word(1, 0, 0, 10, 1, 4, 9, 4, 9), 0, a);
      add_row(make_word(1, 0, 0, 10, 0, 2, 3, 8, 3), 0, a);
      add_row(make_word(1, 0, 0, 10, 0, 12, 3, 20, 3), 0, a);
      add_row(make_word(1, 0, 0, 10, 0, 20, 5, 14, -5), 0, a);
      add_row(make_word(1, 0, 0, 10, 0, 3, 2, 5, 9), 0, a);
      add_row(make_word(1, 0, 0, 4, 4, 7, 6, 12, 5), 0, a);
      add_row(make_word(1, 0, 0, 4, 4, -3, -1, -9, -2), 0, a);
      add_row(make_word(0, 1, 1, 1, 1, 9, -9, 0, 0), 0, a);
      add_row(make_word(0, -32768, -32768, 32767, 32767, 32767, -32768, 0, 0), 0, a);
      add_row(make_word(1, -32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767), 0, a);
      add_row(make_word(1, 32767, 32767, 32767, -32768, -32768, -32768, -32768, 32767), 0, a);
      add_row(make_word(1, -32768, 32767, 32767, -32768, -32768, -32768, -32768, -32768), 0, a);
      add_row(make_word(1, 32767, 32767, -32768, -32768, 32767, 32767, -32768, -32768), 0, a);
      add_row(make_word(0, -1, -1, -1, -1, -1, -1, -1, -1), 0, a);
      add_row(make_word(1, 0, 0, 3, 1, 1, 2, 2, -1), 0, a);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         send_word(rows[i].word, rows[i].has_answer, rows[i].answer);
         idle_for(gap_length());
      end
      wait_idle();

      for (int p = 0; p < 4; p++) begin
         write_limit(p == 2 ? 16'($urandom_range(2, 65534)) : limits[p]);
         if (p == 1) hold_off = 1;
         for (int n = 0; n < NUM_RANDOM / 4; n++) begin
            send_word(random_word(), 0, a);
            if ((n % 64) > 40) idle_for(gap_length());
         end
         wait_idle();
      end

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### segment_closest_points_2d.f
design/scp2d_pkg.sv
design/segment_closest_points_2d.sv
verif/testbench.sv
